FILE: hdl/ersd_pkg.sv
package ersd_pkg;

  localparam int unsigned MaxClients   = 16;
  localparam int unsigned MaxRequests  = 16;
  localparam logic [7:0]  MockSgCount  = 8'd3;
  localparam int unsigned FifoDepth    = 2;

  typedef enum logic [1:0] {
    OP_REGISTER = 2'd0,
    OP_SUBMIT   = 2'd1,
    OP_SG_DONE  = 2'd2,
    OP_REQ_DONE = 2'd3
  } op_e;

  typedef enum logic [2:0] {
    ST_OK         = 3'd0,
    ST_DUPLICATE  = 3'd1,
    ST_UNREG      = 3'd2,
    ST_UNKNOWN    = 3'd3,
    ST_FULL       = 3'd4,
    ST_ALREADY    = 3'd5
  } status_e;

  typedef struct packed {
    logic [1:0]  op;
    logic [3:0]  client;
    logic [31:0] req_tag;
    logic [62:0] release_time;
  } in_item_t;

  typedef struct packed {
    logic [2:0]  status;
    logic        launch_valid;
    logic [3:0]  launch_client;
    logic [31:0] launch_tag;
    logic [7:0]  launch_subgraph;
    logic        unblock_valid;
    logic [3:0]  unblock_client;
  } out_item_t;

endpackage

FILE: hdl/ersd_front.sv
// input queue front: holds accepted items until the back end takes them
module ersd_front #(
  parameter int unsigned Depth = ersd_pkg::FifoDepth
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push_i,
  output logic               full_o,
  input  ersd_pkg::in_item_t data_i,
  output logic               valid_o,
  input  logic               take_i,
  output ersd_pkg::in_item_t data_o
);
  import ersd_pkg::*;

  localparam int unsigned Aw = (Depth > 1) ? $clog2(Depth) : 1;

  in_item_t          mem_q [Depth];
  logic [Aw-1:0]     wr_q, wr_d, rd_q, rd_d;
  logic [Aw:0]       cnt_q, cnt_d;
  logic              do_push, do_pop;

  assign full_o  = (cnt_q == (Aw+1)'(Depth));
  assign valid_o = (cnt_q != '0);
  assign data_o  = mem_q[rd_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = take_i && valid_o;

  always_comb begin
    wr_d  = wr_q;
    rd_d  = rd_q;
    cnt_d = cnt_q;
    if (do_push) begin
      wr_d = (wr_q == Aw'(Depth - 1)) ? '0 : wr_q + 1'b1;
    end
    if (do_pop) begin
      rd_d = (rd_q == Aw'(Depth - 1)) ? '0 : rd_q + 1'b1;
    end
    if (do_push && !do_pop) cnt_d = cnt_q + 1'b1;
    else if (!do_push && do_pop) cnt_d = cnt_q - 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) mem_q[wr_q] <= data_i;
  end

endmodule

FILE: hdl/ersd_back.sv
// back end: sequencer that scans the slot table one entry per cycle
module ersd_back #(
  parameter int unsigned MaxClients  = ersd_pkg::MaxClients,
  parameter int unsigned MaxRequests = ersd_pkg::MaxRequests
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic [7:0]          seq_len_i,
  input  logic                valid_i,
  input  ersd_pkg::in_item_t  data_i,
  output logic                take_o,
  output logic                empty_o,
  input  logic                pop_i,
  output ersd_pkg::out_item_t result_o
);
  import ersd_pkg::*;

  localparam int unsigned Sw = (MaxRequests > 1) ? $clog2(MaxRequests) : 1;
  localparam int unsigned Cw = (MaxClients > 1) ? $clog2(MaxClients) : 1;

  typedef enum logic [4:0] {
    S_IDLE   = 5'b00001,
    S_LOOKUP = 5'b00010,
    S_DECIDE = 5'b00100,
    S_SCAN   = 5'b01000,
    S_OUT    = 5'b10000
  } state_e;

  state_e          state_q, state_d;
  logic [MaxClients-1:0]  reg_q;
  logic [MaxRequests-1:0] valid_q;
  logic [3:0]      sl_client_q  [MaxRequests];
  logic [31:0]     sl_rid_q     [MaxRequests];
  logic [62:0]     sl_rel_q     [MaxRequests];
  logic [7:0]      sl_next_q    [MaxRequests];
  logic            busy_q;

  in_item_t        item_q;
  out_item_t       res_q;
  logic            res_full_q;
  logic [Sw:0]     idx_q;
  logic            hit_q, free_found_q, best_found_q;
  logic [Sw-1:0]   hit_idx_q, free_idx_q, best_idx_q;
  logic [62:0]     best_rel_q;
  logic [Sw-1:0    ] i;
  logic            known;
  logic            cl_reg;
  logic [Cw-1:0]   cl_idx;
  logic            go_scan;

  assign i       = idx_q[Sw-1:0];
  assign empty_o = !res_full_q;
  assign result_o = res_q;
  // a new item starts only once the previous result has left
  assign take_o  = state_q[0] && valid_i && !res_full_q;
  assign known   = ({5'b0, item_q.client} < 9'(MaxClients));
  assign cl_idx  = Cw'(item_q.client);
  assign cl_reg  = known && reg_q[cl_idx];
  // completions retry dispatch only when they hit a slot; a submit only when it took a slot and the worker is idle
  assign go_scan = (item_q.op == OP_SUBMIT) ? (!hit_q && cl_reg && free_found_q && !busy_q)
                                            : ((item_q.op != OP_REGISTER) && hit_q);

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE:   if (valid_i && !res_full_q) state_d = S_LOOKUP;
      S_LOOKUP: if (idx_q == (Sw+1)'(MaxRequests - 1)) state_d = S_DECIDE;
      S_DECIDE: state_d = go_scan ? S_SCAN : S_OUT;
      S_SCAN:   if (idx_q == (Sw+1)'(MaxRequests - 1)) state_d = S_OUT;
      S_OUT:    if (!res_full_q) state_d = S_IDLE;
      default:  state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      reg_q        <= '0;
      valid_q      <= '0;
      busy_q       <= 1'b0;
      res_full_q   <= 1'b0;
      idx_q        <= '0;
      hit_q        <= 1'b0;
      free_found_q <= 1'b0;
      best_found_q <= 1'b0;
    end else begin
      if (pop_i && res_full_q) res_full_q <= 1'b0;
      unique case (state_q)
        S_IDLE: begin
          if (valid_i && !res_full_q) begin
            item_q       <= data_i;
            idx_q        <= '0;
            hit_q        <= 1'b0;
            free_found_q <= 1'b0;
            res_q        <= '0;
          end
        end
        S_LOOKUP: begin
          if (valid_q[i] && sl_client_q[i] == item_q.client && sl_rid_q[i] == item_q.req_tag
              && !hit_q) begin
            hit_q     <= 1'b1;
            hit_idx_q <= i;
          end
          if (!valid_q[i] && !free_found_q) begin
            free_found_q <= 1'b1;
            free_idx_q   <= i;
          end
          idx_q <= idx_q + 1'b1;
        end
        S_DECIDE: begin
          idx_q        <= '0;
          best_found_q <= 1'b0;
          unique case (op_e'(item_q.op))
            OP_REGISTER: begin
              if (!known) res_q.status <= ST_UNREG;
              else if (cl_reg) res_q.status <= ST_ALREADY;
              else reg_q[cl_idx] <= 1'b1;
            end
            OP_SUBMIT: begin
              if (hit_q) res_q.status <= ST_DUPLICATE;
              else if (!cl_reg) begin
                res_q.status         <= ST_UNREG;
                res_q.unblock_valid  <= 1'b1;
                res_q.unblock_client <= item_q.client;
              end else if (!free_found_q) res_q.status <= ST_FULL;
              else begin
                valid_q[free_idx_q]     <= 1'b1;
                sl_client_q[free_idx_q] <= item_q.client;
                sl_rid_q[free_idx_q]    <= item_q.req_tag;
                sl_rel_q[free_idx_q]    <= item_q.release_time;
                sl_next_q[free_idx_q]   <= '0;
              end
            end
            default: begin
              busy_q <= 1'b0;
              if (!hit_q) res_q.status <= ST_UNKNOWN;
              else begin
                if (item_q.op == OP_REQ_DONE) begin
                  valid_q[hit_idx_q]   <= 1'b0;
                  res_q.unblock_valid  <= 1'b1;
                  res_q.unblock_client <= item_q.client;
                end
              end
            end
          endcase
        end
        S_SCAN: begin
          if (valid_q[i] && sl_next_q[i] < seq_len_i
              && (!best_found_q || sl_rel_q[i] < best_rel_q)) begin
            best_found_q <= 1'b1;
            best_idx_q   <= i;
            best_rel_q   <= sl_rel_q[i];
          end
          idx_q <= idx_q + 1'b1;
        end
        S_OUT: begin
          if (!res_full_q) begin
            res_full_q <= 1'b1;
            if (best_found_q) begin
              res_q.launch_valid      <= 1'b1;
              res_q.launch_client     <= sl_client_q[best_idx_q];
              res_q.launch_tag        <= sl_rid_q[best_idx_q];
              res_q.launch_subgraph   <= sl_next_q[best_idx_q];
              sl_next_q[best_idx_q]   <= sl_next_q[best_idx_q] + 1'b1;
              busy_q                  <= 1'b1;
              best_found_q            <= 1'b0;
            end
          end
        end
        default: ;
      endcase
      state_q <= state_d;
    end
  end

endmodule

FILE: hdl/earliest_release_subgraph_dispatcher_core.sv
// channel  | handshake           | payload
// in       | push_i / full_o     | in_data_i  (ersd_pkg::in_item_t)
// out      | pop_i / empty_o     | out_data_o (ersd_pkg::out_item_t)
// cfg      | apb psel/penable    | reg 0 subgraphs_per_request at 0x0
// an item passes through the back end as one lookup pass over the slot table,
// a decision step and, when a dispatch pass runs, one pass picking the
// earliest release time, before its result is written out
// reset clears registrations, slot valid bits and the busy flag
// a waiting result holds the back end; the two-entry input queue then fills
// and raises full_o
module earliest_release_subgraph_dispatcher_core #(
  parameter int unsigned MaxClients  = ersd_pkg::MaxClients,
  parameter int unsigned MaxRequests = ersd_pkg::MaxRequests
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push_i,
  output logic                full_o,
  input  ersd_pkg::in_item_t  in_data_i,
  output logic                empty_o,
  input  logic                pop_i,
  output ersd_pkg::out_item_t out_data_o,
  input  logic                psel_i,
  input  logic                penable_i,
  input  logic                pwrite_i,
  input  logic [1:0]          paddr_i,
  input  logic [31:0]         pwdata_i,
  output logic [31:0]         prdata_o,
  output logic                pready_o
);
  import ersd_pkg::*;

  logic [7:0] sg_q;
  logic       q_valid, q_take;
  in_item_t   q_data;

  assign pready_o = 1'b1;
  assign prdata_o = (paddr_i == 2'd0) ? {24'b0, sg_q} : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) sg_q <= MockSgCount;
    else if (psel_i && penable_i && pwrite_i && paddr_i == 2'd0) sg_q <= pwdata_i[7:0];
  end

  ersd_front u_front (
    .clk_i, .rst_ni, .push_i, .full_o, .data_i(in_data_i),
    .valid_o(q_valid), .take_i(q_take), .data_o(q_data)
  );

  ersd_back #(.MaxClients(MaxClients), .MaxRequests(MaxRequests)) u_back (
    .clk_i, .rst_ni, .seq_len_i(sg_q), .valid_i(q_valid), .data_i(q_data),
    .take_o(q_take), .empty_o, .pop_i, .result_o(out_data_o)
  );

endmodule

FILE: hdl/ersd_checker.sv
module ersd_checker (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                empty_o,
  input logic                pop_i,
  input ersd_pkg::out_item_t out_data_o
);
  import ersd_pkg::*;

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty_o && !pop_i |=> !empty_o && $stable(out_data_o)) else $error("result changed");
  a_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty_o |-> out_data_o.status <= 3'd5) else $error("bad status");
  a_launch: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty_o && out_data_o.launch_valid |-> out_data_o.status == ST_OK) else $error("launch");
  a_unblk: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty_o && !out_data_o.unblock_valid |-> out_data_o.unblock_client == 4'd0)
    else $error("unblock");
endmodule

bind earliest_release_subgraph_dispatcher_core ersd_checker u_chk (
  .clk_i, .rst_ni, .empty_o, .pop_i, .out_data_o
);
